// ===== hw/rtl/daq_pkg.sv =====
// Shared types and constants for the deadline-ordered alarm queue.
package daq_pkg;

  localparam int unsigned DAQ_DEPTH = 16;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] delay_seconds;
    logic [7:0]  alarm_tag;
  } daq_in_t;

  typedef struct packed {
    logic        fired;
    logic [7:0]  fired_tag;
    logic [15:0] fired_delay;
    logic        dropped;
    logic [4:0]  pending_count;
  } daq_out_t;

  // One queue slot
  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [7:0]  tag;
    logic [15:0] delay;
  } daq_entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } daq_ctrl_t;

endpackage

// ===== hw/rtl/deadline_ordered_alarm_queue.sv =====
// Alarm queue kept sorted by deadline in a row of compare-and-shift cells.
//
// Each transfer is first latched in the capture register, which forms
// now+delay and now+1; then every cell compares against the new deadline
// (or the head against the new time) and shifts by one slot, and the result
// register loads. A new item is taken only once the previous one has
// executed, so items never overlap, and a result that waits at the output
// holds the latched item back from executing. Equal deadlines
// fire newest first, at most one alarm expires per tick, and an insert into
// a full queue is dropped and flagged. Deadlines compare by signed 32-bit
// difference, so the seconds counter may wrap.
module deadline_ordered_alarm_queue import daq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DAQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  daq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output daq_out_t out_data
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Latched item
  logic        busy;
  logic        cmd_q;
  logic [15:0] delay_q;
  logic [7:0]  tag_q;
  logic [31:0] dl_q;
  logic [31:0] now_inc_q;

  logic [31:0]     now_seconds;
  logic [CntW-1:0] count;

  daq_entry_t entries [QUEUE_DEPTH];
  logic       befores [QUEUE_DEPTH];
  daq_entry_t new_entry;
  daq_ctrl_t  ctrl;

  logic            exec;
  logic            full;
  logic            fire;
  logic [31:0]     head_diff;
  logic [CntW-1:0] count_next;
  logic [CntW+4:0] count_wide;

  assign in_ready = !busy;
  assign exec     = busy && (!out_valid || out_ready);
  assign full     = entries[QUEUE_DEPTH-1].valid;

  // Head due when now+1 is not before its deadline
  assign head_diff = now_inc_q - entries[0].deadline;
  assign fire      = (cmd_q == CMD_TICK) && entries[0].valid && !head_diff[31];

  assign new_entry = '{valid: 1'b1, deadline: dl_q, tag: tag_q, delay: delay_q};
  assign ctrl.ins  = exec && (cmd_q == CMD_INSERT) && !full;
  assign ctrl.pop  = exec && fire;

  // Cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    daq_entry_t left_e;
    daq_entry_t right_e;
    logic       left_b;
    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_b = befores[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = entries[i+1];
    end
    daq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .left_entry (left_e),
      .left_before(left_b),
      .right_entry(right_e),
      .entry      (entries[i]),
      .ahead      (befores[i])
    );
  end

  // Occupancy after this step
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CntW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CntW'(1);
    end
  end
  assign count_wide = {5'b0, count_next};

  // Item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy      <= 1'b1;
      cmd_q     <= in_data.cmd;
      delay_q   <= in_data.delay_seconds;
      tag_q     <= in_data.alarm_tag;
      dl_q      <= now_seconds + {16'b0, in_data.delay_seconds};
      now_inc_q <= now_seconds + 32'd1;
    end else if (exec) begin
      busy <= 1'b0;
    end
  end

  // Time, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else if (exec) begin
      if (cmd_q == CMD_TICK) begin
        now_seconds <= now_inc_q;
      end
      count                  <= count_next;
      out_valid              <= 1'b1;
      out_data.fired         <= fire;
      out_data.fired_tag     <= fire ? entries[0].tag : 8'd0;
      out_data.fired_delay   <= fire ? entries[0].delay : 16'd0;
      out_data.dropped       <= (cmd_q == CMD_INSERT) && full;
      out_data.pending_count <= count_wide[4:0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/daq_cell.sv =====
// One slot of the sorted queue: holds an entry, compares it, shifts with neighbors.
module daq_cell import daq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  daq_ctrl_t  ctrl,
  input  daq_entry_t new_entry,
  input  daq_entry_t left_entry,
  input  logic       left_before,
  input  daq_entry_t right_entry,
  output daq_entry_t entry,
  output logic       ahead
);

  logic [31:0] diff;

  // Entry stays ahead of the new alarm when its deadline is strictly earlier
  assign diff  = entry.deadline - new_entry.deadline;
  assign ahead = entry.valid && diff[31];

  // Insert: keep, take the new alarm at the boundary, else shift right; pop shifts left
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.ins && !ahead) begin
      if (left_before) begin
        entry <= new_entry;
      end else begin
        entry <= left_entry;
      end
    end else if (ctrl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== hw/rtl/daq_checker.sv =====
// Port-level checks for the alarm queue, bound to the top level.
module daq_checker import daq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input daq_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An expiry never reports a drop
  a_fire_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired |-> !out_data.dropped)
    else $error("fired and dropped together");

  // No expiry means empty tag and delay
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.fired |-> out_data.fired_tag == 8'd0 &&
      out_data.fired_delay == 16'd0)
    else $error("tag or delay without expiry");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind deadline_ordered_alarm_queue daq_checker u_daq_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== tb/deadline_ordered_alarm_queue_test.sv =====
// Self-checking testbench for the deadline-ordered alarm queue.
`timescale 1ns / 1ps

module deadline_ordered_alarm_queue_test;
  import daq_pkg::*;

  localparam int ITEM_TARGET    = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int DIRECTED_ROWS  = 21;

  // One pending alarm as the predictor keeps it
  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  tag;
    logic [15:0] delay;
  } alarm_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    daq_in_t  item;
    logic     typed;
    daq_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  daq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  daq_out_t out_data;

  // Predictor state
  alarm_t      pending_alarms[$];
  logic [31:0] seconds_now;

  daq_out_t awaited_reports[$];
  int       fault_count;
  int       items_sent;
  bit       calm_phase;

  // Directed table: extremes, equal deadlines, late sooner insert, zero delay
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // tick on an empty queue
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 5'd0}},
    // longest delay, all-ones tag: stays pending for the whole run
    '{'{CMD_INSERT, 16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 5'd1}},
    // zero delay fires on the next tick
    '{'{CMD_INSERT, 16'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 5'd2}},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b1, '{1'b1, 8'h00, 16'h0000, 1'b0, 5'd1}},
    // equal deadlines go newest first
    '{'{CMD_INSERT, 16'd3,    8'h11}, 1'b0, '0},
    '{'{CMD_INSERT, 16'd3,    8'h22}, 1'b0, '0},
    '{'{CMD_INSERT, 16'd1,    8'h33}, 1'b0, '0},
    '{'{CMD_INSERT, 16'd5,    8'hAA}, 1'b0, '0},
    '{'{CMD_TICK,   16'hFFFF, 8'hFF}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   16'h1234, 8'h5A}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    // sooner alarm inserted behind a later one must not be missed
    '{'{CMD_INSERT, 16'd10,   8'h44}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_INSERT, 16'd1,    8'h66}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_INSERT, 16'd0,    8'h5A}, 1'b0, '0},
    '{'{CMD_TICK,   16'h0000, 8'h00}, 1'b0, '0}
  };

  deadline_ordered_alarm_queue #(.QUEUE_DEPTH(DAQ_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a is earlier than b by signed 32-bit difference
  function automatic bit earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  // Advance the predicted queue by one item and return its report
  function automatic daq_out_t predict_alarm_step(daq_in_t item);
    daq_out_t rep;
    alarm_t   a;
    int       pos;
    rep = '0;
    if (item.cmd == CMD_INSERT) begin
      if (pending_alarms.size() >= DAQ_DEPTH) begin
        rep.dropped = 1'b1;
      end else begin
        a.deadline = seconds_now + 32'(item.delay_seconds);
        a.tag = item.alarm_tag;
        a.delay = item.delay_seconds;
        pos = 0;
        while (pos < pending_alarms.size() && earlier(pending_alarms[pos].deadline, a.deadline))
          pos++;
        pending_alarms.insert(pos, a);
      end
    end else begin
      seconds_now = seconds_now + 32'd1;
      if (pending_alarms.size() > 0 && !earlier(seconds_now, pending_alarms[0].deadline)) begin
        a = pending_alarms.pop_front();
        rep.fired = 1'b1;
        rep.fired_tag = a.tag;
        rep.fired_delay = a.delay;
      end
    end
    rep.pending_count = 5'(pending_alarms.size());
    return rep;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 12));
    if (r < 95) return 16'($urandom_range(13, 80));
    return 16'($urandom_range(81, 400));
  endfunction

  function automatic daq_in_t make_insert();
    daq_in_t it;
    it.cmd = CMD_INSERT;
    it.delay_seconds = pick_delay();
    it.alarm_tag = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Ticks carry random junk in the unused fields
  function automatic daq_in_t make_tick();
    daq_in_t it;
    it.cmd = CMD_TICK;
    it.delay_seconds = 16'($urandom_range(0, 65535));
    it.alarm_tag = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic flag_fault(input string msg);
    if (fault_count < 40)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    fault_count++;
  endtask

  // Drive one item after an idle gap and hold it until the transfer
  task automatic send_item(input daq_in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Transfer one item and queue what it should report
  task automatic issue(input daq_in_t item, input logic typed, input daq_out_t want);
    daq_out_t rep;
    send_item(item, pick_gap());
    rep = predict_alarm_step(item);
    awaited_reports.push_back(typed ? want : rep);
    items_sent++;
  endtask

  // Stimulus
  initial begin
    int kind;
    int n_ins;
    int n_tick;
    fault_count = 0;
    items_sent = 0;
    calm_phase = 1'b0;
    seconds_now = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      calm_phase = ($urandom_range(0, 5) == 0);
      n_ins = 0;
      n_tick = 0;
      case (kind)
        0, 1, 2, 3, 4: begin
          n_ins = $urandom_range(1, 8);
          n_tick = $urandom_range(1, 15);
        end
        // long burst can run the queue full and into drops
        5, 6: begin
          n_ins = $urandom_range(12, 20);
          n_tick = $urandom_range(15, 40);
        end
        7: begin
          repeat (10) begin
            if ($urandom_range(0, 1) == 1) issue(make_insert(), 1'b0, '0);
            else issue(make_tick(), 1'b0, '0);
          end
        end
        default: begin
          n_tick = $urandom_range(5, 40);
        end
      endcase
      repeat (n_ins) issue(make_insert(), 1'b0, '0);
      repeat (n_tick) issue(make_tick(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    calm_phase = 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: check each transfer and stall at random
  int stall_left = 0;
  always @(posedge clk) begin
    daq_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          flag_fault("result with nothing pending");
        end else begin
          want = awaited_reports.pop_front();
          if (out_data.fired !== want.fired)
            flag_fault($sformatf("fired got %0d want %0d", out_data.fired, want.fired));
          if (out_data.fired_tag !== want.fired_tag)
            flag_fault($sformatf("fired_tag got %0h want %0h",
                                 out_data.fired_tag, want.fired_tag));
          if (out_data.fired_delay !== want.fired_delay)
            flag_fault($sformatf("fired_delay got %0d want %0d",
                                 out_data.fired_delay, want.fired_delay));
          if (out_data.dropped !== want.dropped)
            flag_fault($sformatf("dropped got %0d want %0d", out_data.dropped, want.dropped));
          if (out_data.pending_count !== want.pending_count)
            flag_fault($sformatf("pending_count got %0d want %0d",
                                 out_data.pending_count, want.pending_count));
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
